// ----- sv/sst_pkg.sv -----
// shared types and constants of the scoped symbol table
// request and response beats, entry layout, request and status codes
package sst_pkg;

  localparam int DEPTH = 256;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] REQ_ADD_VAR    = 3'd0;
  localparam logic [2:0] REQ_ADD_FUNC   = 3'd1;
  localparam logic [2:0] REQ_FIND_VAR   = 3'd2;
  localparam logic [2:0] REQ_FIND_FUNC  = 3'd3;
  localparam logic [2:0] REQ_SET_LENGTH = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_LENMIS   = 3'd3;
  localparam logic [2:0] ST_BAD      = 3'd4;

  localparam logic [1:0] KIND_VAR  = 2'd1;
  localparam logic [1:0] KIND_FUNC = 2'd2;

  localparam logic [1:0] VT_UNKNOWN = 2'd0;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [63:0]        name_key;
    logic [7:0]         scope_id;
    logic [1:0]         value_type;
    logic [7:0]         length_value;
    logic signed [31:0] init_value;
    logic [7:0]         target_index;
  } sst_req_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] status;
    logic [7:0] entry_index;
  } sst_rsp_t;

  typedef struct packed {
    logic [63:0]        key;
    logic [7:0]         scope;
    logic [1:0]         kind;
    logic [1:0]         vtype;
    logic [7:0]         length;
    logic signed [31:0] init;
  } sst_entry_t;

  function automatic logic [7:0] to_idx8(input logic [CNT_W-1:0] v);
    logic [CNT_W+7:0] w;
    w = {8'b0, v};
    return w[7:0];
  endfunction

endpackage

// ----- sv/scoped_symbol_table_core.sv -----
// scoped symbol table top level: request sequencer over one entry ram
// depends on sst_pkg and sst_ram
//
// usage:
//   in channel (in_valid, in_stall, in_beat) carries one request beat; out
//   channel (out_valid, out_stall, out_beat) returns exactly one response
//   beat per request, in order. cfg_wen/cfg_wdata write the global scope id;
//   write it only while no request is in flight.
// timing:
//   one request at a time. searches walk the stored entries from index 0,
//   one ram read and one compare per cycle; find_var falling back to the
//   global scope walks twice. set_length is a read-modify-write of one
//   entry; bad request codes and bad indexes answer straight from idle
//   without a walk. the next request beat is taken the cycle after the
//   response is loaded. the single ram read port sets the rate.
// reset:
//   synchronous rst empties the table (entry count to zero), sets the
//   global scope to 0 and drops any pending response; in_stall is high
//   while rst is high. ram contents are not cleared; entries at or above
//   the count are never used.
// stall:
//   the response waits in the output register while out_stall is high;
//   a new request is still taken, but its response is held back until
//   the output register is free.
module scoped_symbol_table_core
  import sst_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  sst_req_t in_beat,
  output logic     out_valid,
  input  logic     out_stall,
  output sst_rsp_t out_beat,
  input  logic     cfg_wen,
  input  logic [7:0] cfg_wdata
);

  localparam int ENTRY_W = $bits(sst_entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RMW_RD,
    S_RMW_WR,
    S_DONE
  } state_t;

  state_t           state;
  sst_req_t         req;
  logic [7:0]       gsid;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] cmp_idx;
  logic             cmp_valid;
  logic             pass2;
  logic [2:0]       res_status;
  logic [7:0]       res_idx;

  sst_entry_t       rd_entry;
  sst_entry_t       wr_entry;
  logic [ENTRY_W-1:0] rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] tgt_addr;
  logic [CNT_W+7:0] tgt_full;
  logic [CNT_W+7:0] in_tgt_ext;
  logic [CNT_W+7:0] cnt_ext;
  logic             hit;
  logic             scan_hit;
  logic             scan_end;
  logic             is_add;
  logic             full;
  logic [7:0]       pass_scope;
  logic             out_free;

  assign rd_entry   = sst_entry_t'(rd_data);
  assign tgt_full   = {{CNT_W{1'b0}}, req.target_index};
  assign tgt_addr   = tgt_full[IDX_W-1:0];
  assign in_tgt_ext = {{CNT_W{1'b0}}, in_beat.target_index};
  assign cnt_ext    = {8'b0, count};
  assign is_add     = (req.req_type == REQ_ADD_VAR) || (req.req_type == REQ_ADD_FUNC);
  assign full       = (count == CNT_W'(DEPTH));
  assign pass_scope = pass2 ? gsid : req.scope_id;
  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = rst || (state != S_IDLE);

  always_comb begin
    hit = 1'b0;
    case (req.req_type)
      REQ_ADD_VAR:   hit = (rd_entry.key == req.name_key) && (rd_entry.scope == req.scope_id);
      REQ_ADD_FUNC:  hit = (rd_entry.key == req.name_key);
      REQ_FIND_VAR:  hit = (rd_entry.key == req.name_key) && (rd_entry.scope == pass_scope) &&
                           (rd_entry.kind == KIND_VAR) && (rd_entry.vtype != VT_UNKNOWN);
      REQ_FIND_FUNC: hit = (rd_entry.key == req.name_key) && (rd_entry.scope == gsid) &&
                           (rd_entry.kind == KIND_FUNC) && (rd_entry.vtype != VT_UNKNOWN);
      default:       hit = 1'b0;
    endcase
  end

  assign scan_hit = (state == S_SCAN) && cmp_valid && hit;
  assign scan_end = (state == S_SCAN) && !cmp_valid && !(ptr < count);

  always_comb begin
    rd_addr = ptr[IDX_W-1:0];
    if (state == S_RMW_RD) begin
      rd_addr = tgt_addr;
    end
  end

  // append on a clean add, or write back the entry with its new length
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = count[IDX_W-1:0];
    wr_entry = rd_entry;
    if (state == S_RMW_WR) begin
      wr_en           = 1'b1;
      wr_addr         = tgt_addr;
      wr_entry.length = req.length_value;
    end else if (scan_end && is_add && !full) begin
      wr_en = 1'b1;
      if (req.req_type == REQ_ADD_FUNC) begin
        wr_entry.key    = req.name_key;
        wr_entry.scope  = gsid;
        wr_entry.kind   = KIND_FUNC;
        wr_entry.vtype  = req.value_type;
        wr_entry.length = req.length_value;
        wr_entry.init   = '0;
      end else begin
        wr_entry.key    = req.name_key;
        wr_entry.scope  = req.scope_id;
        wr_entry.kind   = KIND_VAR;
        wr_entry.vtype  = req.value_type;
        wr_entry.length = '0;
        wr_entry.init   = req.init_value;
      end
    end
  end

  sst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gsid      <= '0;
      count     <= '0;
      ptr       <= '0;
      cmp_valid <= 1'b0;
      pass2     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        gsid <= cfg_wdata;
      end
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req       <= in_beat;
            ptr       <= '0;
            cmp_valid <= 1'b0;
            pass2     <= 1'b0;
            res_idx   <= '0;
            unique case (in_beat.req_type)
              REQ_ADD_VAR, REQ_ADD_FUNC, REQ_FIND_VAR, REQ_FIND_FUNC: begin
                state <= S_SCAN;
              end
              REQ_SET_LENGTH: begin
                if (in_tgt_ext < cnt_ext) begin
                  state <= S_RMW_RD;
                end else begin
                  res_status <= ST_BAD;
                  state      <= S_DONE;
                end
              end
              default: begin
                res_status <= ST_BAD;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          cmp_valid <= 1'b0;
          if (scan_hit) begin
            state <= S_DONE;
            if (is_add) begin
              res_status <= ST_DUP;
            end else if ((req.req_type == REQ_FIND_FUNC) &&
                         (rd_entry.length != req.length_value)) begin
              res_status <= ST_LENMIS;
            end else begin
              res_status <= ST_OK;
              res_idx    <= to_idx8(cmp_idx);
            end
          end else if (ptr < count) begin
            ptr       <= ptr + 1'b1;
            cmp_valid <= 1'b1;
            cmp_idx   <= ptr;
          end else if (!cmp_valid) begin
            if (is_add) begin
              state <= S_DONE;
              if (full) begin
                res_status <= ST_BAD;
              end else begin
                res_status <= ST_OK;
                res_idx    <= to_idx8(count);
                count      <= count + 1'b1;
              end
            end else if ((req.req_type == REQ_FIND_VAR) && !pass2) begin
              pass2 <= 1'b1;
              ptr   <= '0;
            end else begin
              res_status <= ST_NOTFOUND;
              state      <= S_DONE;
            end
          end
        end
        S_RMW_RD: begin
          state <= S_RMW_WR;
        end
        S_RMW_WR: begin
          res_status <= ST_OK;
          res_idx    <= req.target_index;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_beat.ok          <= (res_status == ST_OK);
            out_beat.status      <= res_status;
            out_beat.entry_index <= res_idx;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond table depth");

  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_beat.ok == (out_beat.status == ST_OK)))
    else $error("ok flag disagrees with status");

  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_beat.ok) |-> (out_beat.entry_index == 8'd0))
    else $error("entry index nonzero on failed request");

  a_cmp_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (state == S_SCAN))
    else $error("compare pending outside a scan");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (wr_en && (state == S_SCAN)) |=> (count == $past(count) + 1'b1))
    else $error("append did not advance entry count");
`endif

endmodule

// ----- sv/sst_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- verif/scoped_symbol_table_core_tb.sv -----
// self-checking testbench for scoped_symbol_table_core: directed table walk, then random requests
// predicts untyped responses from its own copy of the table; needs sst_pkg and the rtl only
module scoped_symbol_table_core_tb
  import sst_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS       = 1170;
  localparam int HOLD_CYCLES = 700;
  localparam int QUIET_LIMIT = 6000;
  localparam int TAIL_CYCLES = 40;
  localparam int KEY_POOL    = 24;
  localparam int SCOPE_POOL  = 6;

  localparam logic [2:0] REQ_FIRST_UNUSED = REQ_SET_LENGTH + 3'd1;
  localparam logic [1:0] VT_INT   = 2'd1;
  localparam logic [1:0] VT_CHAR  = 2'd2;
  localparam logic [1:0] VT_SPARE = 2'd3;

  localparam logic [63:0] K_ONES = '1;
  localparam logic [63:0] K_ZERO = '0;
  localparam logic [63:0] K_MIX  = 64'hA5A5_5A5A_0F0F_F0F0;
  localparam logic [63:0] K_FN   = 64'h8000_0000_0000_0001;
  localparam logic [63:0] K_FN2  = 64'h7FFF_FFFF_FFFF_FFFE;

  typedef struct {
    sst_req_t req;
    bit       typed;
    sst_rsp_t rsp;
  } dir_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  sst_req_t   in_beat;
  logic       out_valid;
  logic       out_stall;
  sst_rsp_t   out_beat;
  logic       cfg_wen;
  logic [7:0] cfg_wdata;

  sst_entry_t  tbl_ent [DEPTH];
  int          tbl_count;
  logic [7:0]  tbl_gscope;
  sst_rsp_t    pending_rsp [$];
  sst_rsp_t    want;
  dir_row_t    dir_rows [$];
  logic [63:0] key_pool [KEY_POOL];
  logic [7:0]  scope_pool [SCOPE_POOL] = '{8'd0, 8'd1, 8'd2, 8'd128, 8'd254, 8'd255};

  int req_sent;
  int rsp_seen;
  int err_count;
  int quiet_cycles;
  int status_seen [8];
  bit idle_on;
  bit hold_req;

  scoped_symbol_table_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int scan_var(input logic [63:0] key, input logic [7:0] scope);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_ent[i].key == key && tbl_ent[i].scope == scope &&
          tbl_ent[i].kind == KIND_VAR && tbl_ent[i].vtype != VT_UNKNOWN)
        return i;
    end
    return -1;
  endfunction

  function automatic sst_rsp_t table_answer(input sst_req_t r);
    sst_rsp_t   a;
    logic [2:0] st;
    int         idx;
    st  = ST_BAD;
    idx = 0;
    case (r.req_type)
      REQ_ADD_VAR, REQ_ADD_FUNC: begin
        st = ST_OK;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_ent[i].key == r.name_key &&
              (r.req_type == REQ_ADD_FUNC || tbl_ent[i].scope == r.scope_id))
            st = ST_DUP;
        end
        if (st == ST_OK && tbl_count >= DEPTH)
          st = ST_BAD;
        if (st == ST_OK) begin
          idx = tbl_count;
          tbl_ent[idx].key   = r.name_key;
          tbl_ent[idx].vtype = r.value_type;
          if (r.req_type == REQ_ADD_VAR) begin
            tbl_ent[idx].scope  = r.scope_id;
            tbl_ent[idx].kind   = KIND_VAR;
            tbl_ent[idx].length = 8'd0;
            tbl_ent[idx].init   = r.init_value;
          end else begin
            tbl_ent[idx].scope  = tbl_gscope;
            tbl_ent[idx].kind   = KIND_FUNC;
            tbl_ent[idx].length = r.length_value;
            tbl_ent[idx].init   = '0;
          end
          tbl_count++;
        end
      end
      REQ_FIND_VAR: begin
        idx = scan_var(r.name_key, r.scope_id);
        if (idx < 0)
          idx = scan_var(r.name_key, tbl_gscope);
        st = (idx < 0) ? ST_NOTFOUND : ST_OK;
      end
      REQ_FIND_FUNC: begin
        st = ST_NOTFOUND;
        for (int i = 0; i < tbl_count && st == ST_NOTFOUND; i++) begin
          if (tbl_ent[i].key == r.name_key && tbl_ent[i].scope == tbl_gscope &&
              tbl_ent[i].kind == KIND_FUNC && tbl_ent[i].vtype != VT_UNKNOWN) begin
            st  = (tbl_ent[i].length == r.length_value) ? ST_OK : ST_LENMIS;
            idx = i;
          end
        end
      end
      REQ_SET_LENGTH: begin
        if (int'(r.target_index) < tbl_count) begin
          tbl_ent[r.target_index].length = r.length_value;
          idx = r.target_index;
          st  = ST_OK;
        end
      end
      default: ;
    endcase
    a.ok          = (st == ST_OK);
    a.status      = st;
    a.entry_index = (st == ST_OK) ? idx[7:0] : 8'd0;
    return a;
  endfunction

  function automatic sst_req_t random_req();
    sst_req_t r;
    int       pick;
    int       src;
    int       idx;
    r    = '0;
    pick = $urandom_range(0, 99);
    if (pick < 25)      r.req_type = REQ_ADD_VAR;
    else if (pick < 37) r.req_type = REQ_ADD_FUNC;
    else if (pick < 67) r.req_type = REQ_FIND_VAR;
    else if (pick < 85) r.req_type = REQ_FIND_FUNC;
    else if (pick < 97) r.req_type = REQ_SET_LENGTH;
    else                r.req_type = REQ_FIRST_UNUSED + 3'($urandom_range(0, 2));

    src = $urandom_range(0, 9);
    if (src < 6)      r.scope_id = scope_pool[$urandom_range(0, SCOPE_POOL - 1)];
    else if (src < 8) r.scope_id = tbl_gscope;
    else              r.scope_id = 8'($urandom);

    src = $urandom_range(0, 9);
    if (src < 2) begin
      r.name_key = {$urandom, $urandom};
    end else if (src < 6 && tbl_count > 0) begin
      idx = $urandom_range(0, tbl_count - 1);
      r.name_key = tbl_ent[idx].key;
      if ($urandom_range(0, 1) == 0)
        r.scope_id = tbl_ent[idx].scope;
    end else begin
      r.name_key = key_pool[$urandom_range(0, KEY_POOL - 1)];
    end

    src = $urandom_range(0, 9);
    if (src == 0)      r.value_type = VT_UNKNOWN;
    else if (src == 9) r.value_type = VT_SPARE;
    else               r.value_type = (src < 5) ? VT_INT : VT_CHAR;

    r.length_value = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    r.init_value   = $urandom;
    if ($urandom_range(0, 3) != 0)
      r.target_index = 8'($urandom_range(0, (tbl_count < DEPTH) ? tbl_count : DEPTH - 1));
    else
      r.target_index = 8'($urandom);
    return r;
  endfunction

  task automatic dir_row(input logic [2:0] op, input logic [63:0] key, input logic [7:0] scope,
                         input logic [1:0] vt, input logic [7:0] len, input logic [31:0] init,
                         input logic [7:0] tgt, input bit typed, input logic [2:0] st,
                         input logic [7:0] idx);
    dir_row_t d;
    d.req    = '{op, key, scope, vt, len, init, tgt};
    d.typed  = typed;
    d.rsp    = '{st == ST_OK, st, idx};
    dir_rows = {dir_rows, d};
  endtask

  task automatic send_item(input sst_req_t r, input bit typed, input sst_rsp_t typed_rsp);
    sst_rsp_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= r;
    do @(posedge clk); while (in_stall);
    predicted   = table_answer(r);
    pending_rsp = {pending_rsp, (typed ? typed_rsp : predicted)};
    req_sent++;
  endtask

  task automatic write_gscope(input logic [7:0] v);
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen    <= 1'b0;
    tbl_gscope = v;
  endtask

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 50)
      $display("tb: mismatch at response %0d: %s", rsp_seen, what);
  endtask

  // response checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      rsp_seen++;
      if (pending_rsp.size() == 0) begin
        report_mismatch("response with nothing expected");
      end else begin
        want = pending_rsp.pop_front();
        status_seen[want.status]++;
        if (out_beat.ok !== want.ok)
          report_mismatch($sformatf("ok got %b want %b", out_beat.ok, want.ok));
        if (out_beat.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_beat.status, want.status));
        if (out_beat.entry_index !== want.entry_index)
          report_mismatch($sformatf("entry_index got %0d want %0d",
                                    out_beat.entry_index, want.entry_index));
      end
    end
  end

  // receiver side: random stall bursts and one long hold-off
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    sst_req_t r;
    int       closing_n;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_beat   <= '0;
    cfg_wen   <= 1'b0;
    cfg_wdata <= '0;
    tbl_count  = 0;
    tbl_gscope = 8'd0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    key_pool[0] = K_ONES;
    key_pool[1] = K_ZERO;
    for (int i = 2; i < KEY_POOL; i++)
      key_pool[i] = {$urandom, $urandom};

    dir_row(REQ_FIND_VAR,   K_ONES, 8'd0,   VT_INT,     8'd0,   32'd0,         8'd0,   1'b1,
            ST_NOTFOUND, 8'd0);
    dir_row(REQ_FIND_FUNC,  K_ONES, 8'd0,   VT_INT,     8'd0,   32'd0,         8'd0,   1'b1,
            ST_NOTFOUND, 8'd0);
    dir_row(REQ_SET_LENGTH, K_ONES, 8'd0,   VT_INT,     8'd9,   32'd0,         8'd0,   1'b1,
            ST_BAD, 8'd0);
    dir_row(REQ_ADD_VAR,    K_ONES, 8'd255, VT_INT,     8'd255, 32'h7FFF_FFFF, 8'd255, 1'b1,
            ST_OK, 8'd0);
    dir_row(REQ_ADD_VAR,    K_ONES, 8'd255, VT_CHAR,    8'd0,   32'd5,         8'd0,   1'b1,
            ST_DUP, 8'd0);
    dir_row(REQ_ADD_VAR,    K_ZERO, 8'd0,   VT_CHAR,    8'd0,   32'h8000_0000, 8'd0,   1'b1,
            ST_OK, 8'd1);
    dir_row(REQ_ADD_VAR,    K_MIX,  8'd7,   VT_UNKNOWN, 8'd0,   32'hFFFF_FFFF, 8'd0,   1'b1,
            ST_OK, 8'd2);
    dir_row(REQ_FIND_VAR,   K_MIX,  8'd7,   VT_INT,     8'd0,   32'd0,         8'd0,   1'b1,
            ST_NOTFOUND, 8'd0);
    dir_row(REQ_FIND_VAR,   K_ZERO, 8'd9,   VT_INT,     8'd0,   32'd0,         8'd0,   1'b1,
            ST_OK, 8'd1);
    dir_row(REQ_FIND_VAR,   K_ONES, 8'd255, VT_INT,     8'd0,   32'd0,         8'd0,   1'b0,
            ST_OK, 8'd0);
    dir_row(REQ_ADD_FUNC,   K_ONES, 8'd0,   VT_INT,     8'd3,   32'd0,         8'd0,   1'b1,
            ST_DUP, 8'd0);
    dir_row(REQ_ADD_FUNC,   K_FN,   8'd200, VT_INT,     8'd255, 32'h1234_5678, 8'd0,   1'b1,
            ST_OK, 8'd3);
    dir_row(REQ_FIND_FUNC,  K_FN,   8'd0,   VT_INT,     8'd255, 32'd0,         8'd0,   1'b1,
            ST_OK, 8'd3);
    dir_row(REQ_FIND_FUNC,  K_FN,   8'd0,   VT_INT,     8'd0,   32'd0,         8'd0,   1'b1,
            ST_LENMIS, 8'd0);
    dir_row(REQ_SET_LENGTH, K_ZERO, 8'd0,   VT_INT,     8'd0,   32'd0,         8'd3,   1'b1,
            ST_OK, 8'd3);
    dir_row(REQ_FIND_FUNC,  K_FN,   8'd0,   VT_INT,     8'd0,   32'd0,         8'd0,   1'b0,
            ST_OK, 8'd0);
    dir_row(REQ_ADD_FUNC,   K_FN2,  8'd0,   VT_UNKNOWN, 8'd1,   32'd0,         8'd0,   1'b1,
            ST_OK, 8'd4);
    dir_row(REQ_FIND_FUNC,  K_FN2,  8'd0,   VT_INT,     8'd1,   32'd0,         8'd0,   1'b1,
            ST_NOTFOUND, 8'd0);
    dir_row(REQ_ADD_VAR,    K_FN,   8'd0,   VT_INT,     8'd0,   32'd1,         8'd0,   1'b1,
            ST_DUP, 8'd0);
    dir_row(REQ_FIND_VAR,   K_FN,   8'd0,   VT_INT,     8'd0,   32'd0,         8'd0,   1'b1,
            ST_NOTFOUND, 8'd0);
    dir_row(REQ_SET_LENGTH, K_ZERO, 8'd0,   VT_INT,     8'd7,   32'd0,         8'd5,   1'b1,
            ST_BAD, 8'd0);
    dir_row(REQ_SET_LENGTH, K_ZERO, 8'd0,   VT_INT,     8'd7,   32'd0,         8'd255, 1'b1,
            ST_BAD, 8'd0);
    for (int u = 0; u < 3; u++)
      dir_row(REQ_FIRST_UNUSED + 3'(u), K_ONES, 8'd255, VT_SPARE, 8'd255, 32'hFFFF_FFFF,
              8'd255, 1'b1, ST_BAD, 8'd0);
    dir_row(REQ_ADD_VAR,    K_MIX,  8'd1,   VT_SPARE,   8'd0,   32'd42,        8'd0,   1'b1,
            ST_OK, 8'd5);
    dir_row(REQ_FIND_VAR,   K_MIX,  8'd1,   VT_INT,     8'd0,   32'd0,         8'd0,   1'b0,
            ST_OK, 8'd0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_gscope(8'd0);
    foreach (dir_rows[i])
      send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

    write_gscope(8'd255);
    for (int n = 0; n < 300; n++) begin
      if (n == 150)
        hold_req = 1'b1;
      send_item(random_req(), 1'b0, '0);
    end

    write_gscope(scope_pool[$urandom_range(0, SCOPE_POOL - 1)]);
    for (int n = 0; n < 300; n++)
      send_item(random_req(), 1'b0, '0);

    // top the table up with fresh keys so the full case is reached
    write_gscope(8'($urandom));
    while (tbl_count < DEPTH) begin
      r = random_req();
      r.req_type = ($urandom_range(0, 3) == 0) ? REQ_ADD_FUNC : REQ_ADD_VAR;
      r.name_key = {$urandom, $urandom};
      send_item(r, 1'b0, '0);
    end

    write_gscope(8'd0);
    closing_n = (ITEMS - req_sent > 200) ? ITEMS - req_sent : 200;
    for (int n = 0; n < closing_n; n++) begin
      idle_on = (closing_n - n > 150);
      send_item(random_req(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d requests sent, %0d responses checked, table reached %0d of %0d entries",
             req_sent, rsp_seen, tbl_count, DEPTH);
    $display("tb: ok %0d, duplicate %0d, not found %0d, length mismatch %0d, full or bad %0d",
             status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_NOTFOUND],
             status_seen[ST_LENMIS], status_seen[ST_BAD]);
    if (err_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
